### rtl/gra_pkg.sv
package gra_pkg;

  // ratio words are unsigned q8.8
  localparam int unsigned RATIO_W = 16;

  // result index fields are masked to this width
  localparam int unsigned OUT_IDX_W = 4;

  // pipeline stages between a row issue and the running best update
  localparam logic [1:0] DRAIN_CYCLES = 2'd3;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;       // accepted input word, store the pair
    logic issue;      // compare one image row against all frames
    logic pick;       // emit the best pair and mark it used
    logic last_pick;  // this pick closes the set
  } gra_cmd_t;

endpackage

### rtl/gra_ctrl.sv
module gra_ctrl #(
  parameter int unsigned MAX_PAIRS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   last_pair_i,
  input  logic [$clog2(MAX_PAIRS+1)-1:0] count_i,
  output logic                   busy_o,
  output gra_pkg::gra_cmd_t      cmd_o,
  output logic [((MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1)-1:0] row_o,
  output logic                   res_valid_o
);
  import gra_pkg::*;

  localparam int unsigned CW = $clog2(MAX_PAIRS + 1);
  localparam int unsigned IW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_PICK
  } state_e;

  state_e        state_q;
  logic [CW-1:0] row_q;
  logic [CW-1:0] pick_q;
  logic [1:0]    drain_q;
  logic          res_valid_q;
  logic          accept;
  logic          last_row;
  logic          last_pick;

  // handshake and loop end conditions
  assign accept    = start_i && (state_q == ST_IDLE);
  assign last_row  = (CW'(row_q + 1'b1) == count_i);
  assign last_pick = (CW'(pick_q + 1'b1) == count_i);

  // command decode
  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = accept;
    cmd_o.issue     = (state_q == ST_SCAN);
    cmd_o.pick      = (state_q == ST_PICK);
    cmd_o.last_pick = (state_q == ST_PICK) && last_pick;
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign row_o       = row_q[IW-1:0];
  assign res_valid_o = res_valid_q;

  // state and registered strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      row_q       <= '0;
      pick_q      <= '0;
      drain_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= (state_q == ST_PICK);
      unique case (state_q)
        ST_IDLE: begin
          if (accept && last_pair_i) begin
            state_q <= ST_SCAN;
            row_q   <= '0;
            pick_q  <= '0;
          end
        end
        ST_SCAN: begin
          if (last_row) begin
            state_q <= ST_DRAIN;
            drain_q <= '0;
          end else begin
            row_q <= CW'(row_q + 1'b1);
          end
        end
        ST_DRAIN: begin
          if (drain_q == DRAIN_CYCLES - 2'd1) begin
            state_q <= ST_PICK;
          end else begin
            drain_q <= drain_q + 2'd1;
          end
        end
        ST_PICK: begin
          row_q <= '0;
          if (last_pick) begin
            state_q <= ST_IDLE;
            pick_q  <= '0;
          end else begin
            state_q <= ST_SCAN;
            pick_q  <= CW'(pick_q + 1'b1);
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/gra_datapath.sv
module gra_datapath #(
  parameter int unsigned MAX_PAIRS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  gra_pkg::gra_cmd_t              cmd_i,
  input  logic [((MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1)-1:0] row_i,
  input  logic [gra_pkg::RATIO_W-1:0]    image_ratio_i,
  input  logic [gra_pkg::RATIO_W-1:0]    frame_ratio_i,
  output logic [$clog2(MAX_PAIRS+1)-1:0] count_o,
  output logic [gra_pkg::OUT_IDX_W-1:0]  pick_frame_o,
  output logic [gra_pkg::OUT_IDX_W-1:0]  pick_image_o,
  output logic                           last_pick_o
);
  import gra_pkg::*;

  localparam int unsigned CW     = $clog2(MAX_PAIRS + 1);
  localparam int unsigned IW     = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int unsigned LEAVES = 1 << $clog2(MAX_PAIRS);
  localparam int unsigned NODES  = 2 * LEAVES - 1;

  // pair stores, image side read one row at a time
  logic [RATIO_W-1:0] image_mem [MAX_PAIRS];
  logic [RATIO_W-1:0] frame_mem [MAX_PAIRS];

  logic [CW-1:0]        count_q;
  logic [MAX_PAIRS-1:0] image_used_q;
  logic [MAX_PAIRS-1:0] frame_used_q;
  logic                 store_en;

  // row read stage
  logic [RATIO_W-1:0] img_q;
  logic               s0_vld_q;
  logic [IW-1:0]      s0_row_q;

  // difference stage
  logic [RATIO_W-1:0] diff_d [MAX_PAIRS];
  logic [RATIO_W-1:0] diff_q [MAX_PAIRS];
  logic [MAX_PAIRS-1:0] dvld_d;
  logic [MAX_PAIRS-1:0] dvld_q;
  logic [IW-1:0]        s1_row_q;

  // row minimum stage
  logic [RATIO_W-1:0] node_d [NODES];
  logic [IW-1:0]      node_j [NODES];
  logic               node_v [NODES];
  logic [RATIO_W-1:0] rmin_q;
  logic [IW-1:0]      rmin_j_q;
  logic               rmin_vld_q;
  logic [IW-1:0]      s2_row_q;

  // running best of the current pick
  logic [RATIO_W-1:0] best_d_q;
  logic [IW-1:0]      best_i_q;
  logic [IW-1:0]      best_j_q;
  logic               best_found_q;
  logic               best_upd;

  // result word
  logic [OUT_IDX_W-1:0] frame_idx_q;
  logic [OUT_IDX_W-1:0] image_idx_q;
  logic                 last_pick_q;

  assign store_en = cmd_i.load && (count_q < CW'(MAX_PAIRS));
  assign count_o  = count_q;

  // store writes, a full store drops the pair
  always_ff @(posedge clk_i) begin
    if (store_en) begin
      image_mem[count_q[IW-1:0]] <= image_ratio_i;
      frame_mem[count_q[IW-1:0]] <= frame_ratio_i;
    end
  end

  // set count and used flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      image_used_q <= '0;
      frame_used_q <= '0;
    end else begin
      if (store_en) begin
        count_q <= CW'(count_q + 1'b1);
      end
      if (cmd_i.pick) begin
        if (cmd_i.last_pick) begin
          count_q      <= '0;
          image_used_q <= '0;
          frame_used_q <= '0;
        end else begin
          image_used_q[best_i_q] <= 1'b1;
          frame_used_q[best_j_q] <= 1'b1;
        end
      end
    end
  end

  // registered image row read
  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      img_q <= image_mem[row_i];
    end
    s0_row_q <= row_i;
  end

  // absolute differences of one row against every live frame
  always_comb begin
    for (int j = 0; j < MAX_PAIRS; j++) begin
      diff_d[j] = (frame_mem[j] > img_q) ? (frame_mem[j] - img_q) : (img_q - frame_mem[j]);
      dvld_d[j] = s0_vld_q && !frame_used_q[j] && (CW'(j) < count_q);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < MAX_PAIRS; j++) begin
      diff_q[j] <= diff_d[j];
    end
    s1_row_q <= s0_row_q;
  end

  // min tree, left child wins ties so the lowest frame index is kept
  always_comb begin
    for (int k = 0; k < LEAVES; k++) begin
      if (k < MAX_PAIRS) begin
        node_d[LEAVES-1+k] = diff_q[k];
        node_v[LEAVES-1+k] = dvld_q[k];
      end else begin
        node_d[LEAVES-1+k] = '0;
        node_v[LEAVES-1+k] = 1'b0;
      end
      node_j[LEAVES-1+k] = IW'(k);
    end
    for (int k = LEAVES - 2; k >= 0; k--) begin
      if (node_v[2*k+1] && (!node_v[2*k+2] || (node_d[2*k+1] <= node_d[2*k+2]))) begin
        node_d[k] = node_d[2*k+1];
        node_j[k] = node_j[2*k+1];
      end else begin
        node_d[k] = node_d[2*k+2];
        node_j[k] = node_j[2*k+2];
      end
      node_v[k] = node_v[2*k+1] || node_v[2*k+2];
    end
  end

  always_ff @(posedge clk_i) begin
    rmin_q   <= node_d[0];
    rmin_j_q <= node_j[0];
    s2_row_q <= s1_row_q;
  end

  // earlier rows win ties, so only a strictly smaller row minimum replaces the best
  assign best_upd = rmin_vld_q && (!best_found_q || (rmin_q < best_d_q));

  always_ff @(posedge clk_i) begin
    if (best_upd) begin
      best_d_q <= rmin_q;
      best_i_q <= s2_row_q;
      best_j_q <= rmin_j_q;
    end
  end

  // pipeline valids and best flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q     <= 1'b0;
      dvld_q       <= '0;
      rmin_vld_q   <= 1'b0;
      best_found_q <= 1'b0;
    end else begin
      s0_vld_q   <= cmd_i.issue && !image_used_q[row_i];
      dvld_q     <= dvld_d;
      rmin_vld_q <= node_v[0];
      if (cmd_i.pick) begin
        best_found_q <= 1'b0;
      end else if (best_upd) begin
        best_found_q <= 1'b1;
      end
    end
  end

  // result word register
  always_ff @(posedge clk_i) begin
    if (cmd_i.pick) begin
      frame_idx_q <= OUT_IDX_W'(best_j_q);
      image_idx_q <= OUT_IDX_W'(best_i_q);
      last_pick_q <= cmd_i.last_pick;
    end
  end

  assign pick_frame_o = frame_idx_q;
  assign pick_image_o = image_idx_q;
  assign last_pick_o  = last_pick_q;

endmodule

### rtl/greedy_ratio_assignment_top.sv
// A word without last_pair is stored and busy stays low; a full store drops the pair.
// A word with last_pair starts matching of the N stored pairs: busy stays high for
// N picks, each one image row per cycle in the scan state, then the pipeline drain state and the pick state.
// Results are strobed for one cycle and cannot be stalled.
// Reset clears the controller, pair count and used flags; the ratio stores are not cleared.
module greedy_ratio_assignment_top #(
  parameter int unsigned MAX_PAIRS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [gra_pkg::RATIO_W-1:0]   image_ratio_i,
  input  logic [gra_pkg::RATIO_W-1:0]   frame_ratio_i,
  input  logic                          last_pair_i,
  output logic                          result_valid_o,
  output logic [gra_pkg::OUT_IDX_W-1:0] pick_frame_o,
  output logic [gra_pkg::OUT_IDX_W-1:0] pick_image_o,
  output logic                          last_pick_o
);
  import gra_pkg::*;

  localparam int unsigned CW = $clog2(MAX_PAIRS + 1);
  localparam int unsigned IW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;

  gra_cmd_t      cmd;
  logic [CW-1:0] count;
  logic [IW-1:0] row;

  // sequencer
  gra_ctrl #(
    .MAX_PAIRS (MAX_PAIRS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .last_pair_i (last_pair_i),
    .count_i     (count),
    .busy_o      (busy),
    .cmd_o       (cmd),
    .row_o       (row),
    .res_valid_o (result_valid_o)
  );

  // stores, row compare pipeline and result register
  gra_datapath #(
    .MAX_PAIRS (MAX_PAIRS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .row_i         (row),
    .image_ratio_i (image_ratio_i),
    .frame_ratio_i (frame_ratio_i),
    .count_o       (count),
    .pick_frame_o  (pick_frame_o),
    .pick_image_o  (pick_image_o),
    .last_pick_o   (last_pick_o)
  );

endmodule

### tb/gra_checker.sv
module gra_checker #(
  parameter int unsigned MAX_PAIRS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  logic [gra_pkg::RATIO_W-1:0]   image_ratio_i,
  input  logic [gra_pkg::RATIO_W-1:0]   frame_ratio_i,
  input  logic                          last_pair_i,
  input  logic                          result_valid_i,
  input  logic [gra_pkg::OUT_IDX_W-1:0] pick_frame_i,
  input  logic [gra_pkg::OUT_IDX_W-1:0] pick_image_i,
  input  logic                          last_pick_i,
  output int                            error_count_o,
  output int                            pending_o
);

  typedef struct packed {
    logic [gra_pkg::OUT_IDX_W-1:0] frame_sel;
    logic [gra_pkg::OUT_IDX_W-1:0] image_sel;
    logic                          last_pick;
  } pick_t;

  // pairs of the set being loaded
  logic [gra_pkg::RATIO_W-1:0] image_store [MAX_PAIRS];
  logic [gra_pkg::RATIO_W-1:0] frame_store [MAX_PAIRS];
  int unsigned                 stored = 0;

  // picks still owed by the block, oldest first
  pick_t pick_queue [$];
  int    errors     = 0;
  int    errors_q   = 0;
  int    pending_q  = 0;

  assign error_count_o = errors_q;
  assign pending_o     = pending_q;

  // greedy matching of the stored set, image-major scan, first minimum wins
  task automatic plan_assignments();
    logic [MAX_PAIRS-1:0] image_taken;
    logic [MAX_PAIRS-1:0] frame_taken;
    logic                 found;
    int unsigned          best;
    int unsigned          diff;
    int unsigned          bi;
    int unsigned          bj;
    pick_t                pick;
    image_taken = '0;
    frame_taken = '0;
    for (int unsigned k = 0; k < stored; k++) begin
      found = 1'b0;
      best  = 0;
      bi    = 0;
      bj    = 0;
      for (int unsigned i = 0; i < stored; i++) begin
        for (int unsigned j = 0; j < stored; j++) begin
          if (!image_taken[i] && !frame_taken[j]) begin
            if (frame_store[j] > image_store[i]) begin
              diff = frame_store[j] - image_store[i];
            end else begin
              diff = image_store[i] - frame_store[j];
            end
            if (!found || diff < best) begin
              found = 1'b1;
              best  = diff;
              bi    = i;
              bj    = j;
            end
          end
        end
      end
      image_taken[bi] = 1'b1;
      frame_taken[bj] = 1'b1;
      pick.frame_sel  = bj[gra_pkg::OUT_IDX_W-1:0];
      pick.image_sel  = bi[gra_pkg::OUT_IDX_W-1:0];
      pick.last_pick  = (k + 1 == stored);
      pick_queue.push_back(pick);
    end
    stored = 0;
  endtask

  // compare results first, then take in the accepted word
  always @(posedge clk_i) begin
    pick_t want;
    if (!rst_ni) begin
      stored = 0;
      pick_queue.delete();
    end else begin
      if (result_valid_i) begin
        if (pick_queue.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("tb: unexpected result frame=%0d image=%0d last=%0b",
                     pick_frame_i, pick_image_i, last_pick_i);
          end
        end else begin
          want = pick_queue.pop_front();
          if (want.frame_sel !== pick_frame_i || want.image_sel !== pick_image_i ||
              want.last_pick !== last_pick_i) begin
            errors++;
            if (errors <= 10) begin
              $display({"tb: mismatch exp frame=%0d image=%0d last=%0b",
                        " got frame=%0d image=%0d last=%0b"},
                       want.frame_sel, want.image_sel, want.last_pick,
                       pick_frame_i, pick_image_i, last_pick_i);
            end
          end
        end
      end
      if (start_i && !busy_i) begin
        // a full store drops the pair but still honors last_pair
        if (stored < MAX_PAIRS) begin
          image_store[stored] = image_ratio_i;
          frame_store[stored] = frame_ratio_i;
          stored++;
        end
        if (last_pair_i) begin
          plan_assignments();
        end
      end
    end
    errors_q  <= errors;
    pending_q <= pick_queue.size();
  end

endmodule

### tb/tb.sv
module tb;

  localparam int unsigned MAX_PAIRS = 16;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          start;
  logic                          busy;
  logic [gra_pkg::RATIO_W-1:0]   image_ratio;
  logic [gra_pkg::RATIO_W-1:0]   frame_ratio;
  logic                          last_pair;
  logic                          result_valid;
  logic [gra_pkg::OUT_IDX_W-1:0] pick_frame;
  logic [gra_pkg::OUT_IDX_W-1:0] pick_image;
  logic                          last_pick;
  int                            error_count;
  int                            pending;

  int unsigned words    = 0;
  int unsigned sets     = 0;
  int unsigned overruns = 0;

  greedy_ratio_assignment_top #(
    .MAX_PAIRS(MAX_PAIRS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .image_ratio_i (image_ratio),
    .frame_ratio_i (frame_ratio),
    .last_pair_i   (last_pair),
    .result_valid_o(result_valid),
    .pick_frame_o  (pick_frame),
    .pick_image_o  (pick_image),
    .last_pick_o   (last_pick)
  );

  gra_checker #(
    .MAX_PAIRS(MAX_PAIRS)
  ) checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .image_ratio_i (image_ratio),
    .frame_ratio_i (frame_ratio),
    .last_pair_i   (last_pair),
    .result_valid_i(result_valid),
    .pick_frame_i  (pick_frame),
    .pick_image_i  (pick_image),
    .last_pick_i   (last_pick),
    .error_count_o (error_count),
    .pending_o     (pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #2000000;
    $display("tb: done, errors");
    $finish;
  end

  // idle gap before a word: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 88) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // ratio for one field: full range, a tight cluster that forces ties, or corner values
  function automatic logic [15:0] pick_ratio(input int unsigned mode, input logic [15:0] base);
    logic [15:0] r;
    case (mode)
      0: begin
        r = 16'($urandom);
      end
      1: begin
        r = base + 16'($urandom_range(0, 3));
      end
      default: begin
        case ($urandom_range(0, 5))
          0: r = 16'h0000;
          1: r = 16'hFFFF;
          2: r = 16'h0A00;
          3: r = 16'h09FF;
          4: r = 16'h0100;
          default: r = 16'($urandom);
        endcase
      end
    endcase
    return r;
  endfunction

  // present one word and hold it until the block takes it
  task automatic send_word(input logic [15:0] img, input logic [15:0] frm,
                           input logic last, input int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start       <= 1'b1;
    image_ratio <= img;
    frame_ratio <= frm;
    last_pair   <= last;
    do @(posedge clk_i); while (busy);
    words++;
  endtask

  // hold the sender off until every pick has come back
  task automatic drain_picks();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // stimulus and verdict
  initial begin
    int unsigned size;
    int unsigned mode;
    int unsigned r;
    logic        burst;
    logic [15:0] base;
    start       <= 1'b0;
    image_ratio <= '0;
    frame_ratio <= '0;
    last_pair   <= 1'b0;
    rst_ni      <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // lone pair at opposite extremes
    send_word(16'hFFFF, 16'h0000, 1'b1, pick_gap());
    sets++;
    // crossed extremes, both matches have zero difference
    send_word(16'h0000, 16'hFFFF, 1'b0, pick_gap());
    send_word(16'hFFFF, 16'h0000, 1'b1, pick_gap());
    sets++;
    // equal ratios, ties resolve to lowest indices
    for (int k = 0; k < 3; k++) begin
      send_word(16'h0100, 16'h0100, k == 2, pick_gap());
    end
    sets++;
    // full store, then two pairs that are dropped, the second closing the set
    for (int k = 0; k < 18; k++) begin
      if (k < 16) begin
        send_word(16'(k * 16'h1111), 16'(k * 16'h0A00), 1'b0, pick_gap());
      end else begin
        send_word(16'h5A5A, 16'hA5A5, k == 17, pick_gap());
      end
    end
    sets++;
    overruns++;
    drain_picks();

    // random sets, mostly small, some full, a few overrunning the store
    while (words < 320) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        size = $urandom_range(1, 6);
      end else if (r < 92) begin
        size = $urandom_range(7, 16);
      end else begin
        size = $urandom_range(17, 20);
      end
      mode  = $urandom_range(0, 2);
      burst = ($urandom_range(0, 3) == 0);
      base  = 16'($urandom);
      for (int unsigned k = 0; k < size; k++) begin
        send_word(pick_ratio(mode, base), pick_ratio(mode, base), k == size - 1,
                  burst ? 0 : pick_gap());
      end
      sets++;
      if (size > MAX_PAIRS) begin
        overruns++;
      end
      if (sets == 16) begin
        drain_picks();
      end
    end

    drain_picks();
    repeat (400) @(posedge clk_i);

    $display("tb: %0d words in %0d sets, %0d sets overran the store", words, sets, overruns);
    $display("tb: %0d mismatching picks", error_count);
    if (error_count == 0 && pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
